/* hw/rtl/alpha_weighted_box_downscale_defines.svh */
// Assertion macros for the downscaler top level.
`ifndef ALPHA_WEIGHTED_BOX_DOWNSCALE_DEFINES_SVH
`define ALPHA_WEIGHTED_BOX_DOWNSCALE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet during reset.
`define AWBD_ASSERT_IMPL(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on clk, quiet during reset.
`define AWBD_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("assertion failed");
`else
`define AWBD_ASSERT_IMPL(lbl, ant, con)
`define AWBD_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

/* hw/rtl/awbd_pkg.sv */
// Shared constants and the posterize output table of the downscaler.
package awbd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 2'd3;

    localparam int ALPHA_CUTOFF = 110;
    localparam logic [4:0] MAX_LEVEL = 5'd23;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Map a posterize level back to an 8-bit value, level*255/23 rounded.
    function automatic logic [7:0] level_value(input logic [4:0] lvl);
        logic [7:0] v;
        case (lvl)
            5'd0:  v = 8'd0;
            5'd1:  v = 8'd11;
            5'd2:  v = 8'd22;
            5'd3:  v = 8'd33;
            5'd4:  v = 8'd44;
            5'd5:  v = 8'd55;
            5'd6:  v = 8'd67;
            5'd7:  v = 8'd78;
            5'd8:  v = 8'd89;
            5'd9:  v = 8'd100;
            5'd10: v = 8'd111;
            5'd11: v = 8'd122;
            5'd12: v = 8'd133;
            5'd13: v = 8'd144;
            5'd14: v = 8'd155;
            5'd15: v = 8'd166;
            5'd16: v = 8'd177;
            5'd17: v = 8'd188;
            5'd18: v = 8'd200;
            5'd19: v = 8'd211;
            5'd20: v = 8'd222;
            5'd21: v = 8'd233;
            5'd22: v = 8'd244;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/awbd_front.sv */
// Front end: accepts source pixels, accumulates column sums, emits finished boxes.
module awbd_front #(
    parameter int SPRITE_SIDE = 32,
    parameter int MAX_SOURCE_SIDE = 1024,
    parameter int CW = 5,
    parameter int SW = 11,
    parameter int CNTW = 11,
    parameter int JW = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    src_red,
    input  logic [7:0]    src_green,
    input  logic [7:0]    src_blue,
    input  logic [7:0]    src_alpha,
    input  logic [SW-1:0] width_eff,
    input  logic [SW-1:0] height_eff,
    input  logic          restart,
    input  logic          q_full,
    output logic          q_push,
    output logic [JW-1:0] q_data
);

    localparam int AW   = CNTW + 8;
    localparam int SUMW = CNTW + 16;
    localparam int EW   = 3 * SUMW + AW + CNTW;
    localparam int PW   = SW + 1;
    localparam int MW   = CW + 1 + SW;

    typedef enum logic {F_IDLE, F_ACC} fstate_t;

    fstate_t          state_reg;
    logic [SW-1:0]    src_col_reg, src_row_reg;
    logic [CW-1:0]    box_col_reg, box_row_reg;
    logic [SPRITE_SIDE-1:0] valid_reg;
    logic [EW-1:0]    mem [SPRITE_SIDE];
    logic [EW-1:0]    rd_reg;
    logic             rd_valid_reg;
    logic [7:0]       r_reg, g_reg, b_reg, a_reg;

    logic             accept, bad;
    logic [SUMW-1:0]  old_r, old_g, old_b, new_r, new_g, new_b;
    logic [AW-1:0]    old_a, new_a;
    logic [CNTW-1:0]  old_n, new_n;
    logic [MW-1:0]    col_edge, row_edge;
    logic             col_end, row_end, box_end, done;
    logic [PW-1:0]    col_inc, row_inc;

    assign full   = (state_reg != F_IDLE) || q_full;
    assign accept = push && !full;
    assign bad    = (src_col_reg >= width_eff) || (src_row_reg >= height_eff)
                  || (32'(box_col_reg) >= SPRITE_SIDE) || (32'(box_row_reg) >= SPRITE_SIDE);

    // Add the held pixel to the column entry read last cycle
    always_comb
    begin
        {old_r, old_g, old_b, old_a, old_n} = rd_valid_reg ? rd_reg : '0;
        new_r = old_r + SUMW'(r_reg) * SUMW'(a_reg);
        new_g = old_g + SUMW'(g_reg) * SUMW'(a_reg);
        new_b = old_b + SUMW'(b_reg) * SUMW'(a_reg);
        new_a = old_a + AW'(a_reg);
        new_n = old_n + CNTW'(1);
        col_edge = MW'((MW'(box_col_reg) + MW'(1)) * MW'(width_eff) / SPRITE_SIDE);
        row_edge = MW'((MW'(box_row_reg) + MW'(1)) * MW'(height_eff) / SPRITE_SIDE);
        col_end = (MW'(src_col_reg) + MW'(1)) == col_edge;
        row_end = (MW'(src_row_reg) + MW'(1)) == row_edge;
        box_end = col_end && row_end;
        done = (32'(box_col_reg) == SPRITE_SIDE - 1) && (32'(box_row_reg) == SPRITE_SIDE - 1);
        col_inc = PW'(src_col_reg) + PW'(1);
        row_inc = PW'(src_row_reg) + PW'(1);
    end

    assign q_push = (state_reg == F_ACC) && box_end;
    assign q_data = {done, box_row_reg, box_col_reg, new_n, new_a, new_b, new_g, new_r};

    // Hold positions, valid bits and the sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            box_col_reg  <= '0;
            box_row_reg  <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            state_reg    <= F_IDLE;
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            box_col_reg  <= '0;
            box_row_reg  <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_ACC;
                        if (bad)
                        begin
                            src_col_reg  <= '0;
                            src_row_reg  <= '0;
                            box_col_reg  <= '0;
                            box_row_reg  <= '0;
                            valid_reg    <= '0;
                            rd_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            rd_valid_reg <= valid_reg[box_col_reg];
                        end
                    end
                end
                F_ACC:
                begin
                    state_reg <= F_IDLE;
                    valid_reg[box_col_reg] <= !box_end;
                    if (col_end)
                        box_col_reg <= box_col_reg + CW'(1);
                    if (col_inc >= PW'(width_eff))
                    begin
                        src_col_reg <= '0;
                        box_col_reg <= '0;
                        if (row_end)
                            box_row_reg <= box_row_reg + CW'(1);
                        if (row_inc >= PW'(height_eff))
                        begin
                            src_row_reg <= '0;
                            box_row_reg <= '0;
                        end
                        else
                        begin
                            src_row_reg <= row_inc[SW-1:0];
                        end
                    end
                    else
                    begin
                        src_col_reg <= col_inc[SW-1:0];
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // Latch the pixel and read its column entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg  <= src_red;
            g_reg  <= src_green;
            b_reg  <= src_blue;
            a_reg  <= src_alpha;
            rd_reg <= mem[bad ? CW'(0) : box_col_reg];
        end
        if (state_reg == F_ACC)
            mem[box_col_reg] <= {new_r, new_g, new_b, new_a, new_n};
    end

endmodule

/* hw/rtl/awbd_queue.sv */
// Short job queue between the front and back ends.
module awbd_queue #(
    parameter int JW = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  logic [JW-1:0] wdata,
    output logic          q_full,
    input  logic          rd,
    output logic          q_empty,
    output logic [JW-1:0] rdata
);

    logic [JW-1:0] slot_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rdata   = slot_reg[rp_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && !q_full)
                wp_reg <= !wp_reg;
            if (rd && !q_empty)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr && !q_full) - 2'(rd && !q_empty);
        end
    end

    // Store incoming jobs
    always_ff @(posedge clk)
    begin
        if (wr && !q_full)
            slot_reg[wp_reg] <= wdata;
    end

endmodule

/* hw/rtl/awbd_back.sv */
// Back end: divides box sums, posterizes and holds the finished sprite pixel.
module awbd_back #(
    parameter int CW = 5,
    parameter int CNTW = 11,
    parameter int JW = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  logic [JW-1:0] q_data,
    output logic          q_pop,
    input  logic [11:0]   dest_x,
    input  logic [11:0]   dest_y,
    output logic          empty,
    input  logic          pop,
    output logic [12:0]   atlas_x,
    output logic [12:0]   atlas_y,
    output logic [7:0]    out_red,
    output logic [7:0]    out_green,
    output logic [7:0]    out_blue,
    output logic [7:0]    out_alpha,
    output logic          sprite_done
);

    localparam int AW   = CNTW + 8;
    localparam int SUMW = CNTW + 16;
    localparam int NW   = AW + 14;

    typedef enum logic [2:0] {B_IDLE, B_LOAD, B_DIV, B_POST, B_HOLD} bstate_t;

    bstate_t         state_reg;
    logic [SUMW-1:0] sr_reg, sg_reg, sb_reg;
    logic [AW-1:0]   sa_reg;
    logic [CNTW-1:0] n_reg;
    logic [CW-1:0]   col_reg, row_reg;
    logic            done_reg, opaque_reg;
    logic [NW-1:0]   rem_r_reg, rem_g_reg, rem_b_reg, den_reg;
    logic [4:0]      q_r_reg, q_g_reg, q_b_reg;
    logic [2:0]      k_reg;
    logic [12:0]     ax_reg, ay_reg;
    logic [7:0]      or_reg, og_reg, ob_reg, oa_reg;
    logic            od_reg;

    logic [NW-1:0]   dsh;
    logic [4:0]      lr, lg, lb;

    assign q_pop = (state_reg == B_IDLE) && !q_empty;
    assign dsh   = den_reg << k_reg;

    // Clamp levels to the top step
    always_comb
    begin
        lr = (q_r_reg > awbd_pkg::MAX_LEVEL) ? awbd_pkg::MAX_LEVEL : q_r_reg;
        lg = (q_g_reg > awbd_pkg::MAX_LEVEL) ? awbd_pkg::MAX_LEVEL : q_g_reg;
        lb = (q_b_reg > awbd_pkg::MAX_LEVEL) ? awbd_pkg::MAX_LEVEL : q_b_reg;
    end

    // Sequence the job through load, divide and post
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            case (state_reg)
                B_IDLE: if (!q_empty) state_reg <= B_LOAD;
                B_LOAD: state_reg <= B_DIV;
                B_DIV:  if (k_reg == 3'd0) state_reg <= B_POST;
                B_POST: state_reg <= B_HOLD;
                B_HOLD: if (pop) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign empty = (state_reg != B_HOLD);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                {done_reg, row_reg, col_reg, n_reg, sa_reg, sb_reg, sg_reg, sr_reg} <= q_data;
            end
            B_LOAD:
            begin
                rem_r_reg  <= NW'(sr_reg) * NW'(46) + NW'(sa_reg) * NW'(255);
                rem_g_reg  <= NW'(sg_reg) * NW'(46) + NW'(sa_reg) * NW'(255);
                rem_b_reg  <= NW'(sb_reg) * NW'(46) + NW'(sa_reg) * NW'(255);
                den_reg    <= NW'(sa_reg) * NW'(510);
                opaque_reg <= (sa_reg != '0) && ((AW+7)'(sa_reg)
                              >= (AW+7)'(n_reg) * (AW+7)'(awbd_pkg::ALPHA_CUTOFF));
                k_reg      <= 3'd4;
            end
            B_DIV:
            begin
                // One restoring step per quotient bit
                if (rem_r_reg >= dsh)
                begin
                    rem_r_reg <= rem_r_reg - dsh;
                    q_r_reg[k_reg] <= 1'b1;
                end
                else
                    q_r_reg[k_reg] <= 1'b0;
                if (rem_g_reg >= dsh)
                begin
                    rem_g_reg <= rem_g_reg - dsh;
                    q_g_reg[k_reg] <= 1'b1;
                end
                else
                    q_g_reg[k_reg] <= 1'b0;
                if (rem_b_reg >= dsh)
                begin
                    rem_b_reg <= rem_b_reg - dsh;
                    q_b_reg[k_reg] <= 1'b1;
                end
                else
                    q_b_reg[k_reg] <= 1'b0;
                k_reg <= k_reg - 3'd1;
            end
            B_POST:
            begin
                ax_reg <= 13'(dest_x) + 13'(col_reg);
                ay_reg <= 13'(dest_y) + 13'(row_reg);
                or_reg <= opaque_reg ? awbd_pkg::level_value(lr) : 8'd0;
                og_reg <= opaque_reg ? awbd_pkg::level_value(lg) : 8'd0;
                ob_reg <= opaque_reg ? awbd_pkg::level_value(lb) : 8'd0;
                oa_reg <= opaque_reg ? awbd_pkg::ALPHA_OPAQUE : 8'd0;
                od_reg <= done_reg;
            end
            default: ;
        endcase
    end

    assign atlas_x     = ax_reg;
    assign atlas_y     = ay_reg;
    assign out_red     = or_reg;
    assign out_green   = og_reg;
    assign out_blue    = ob_reg;
    assign out_alpha   = oa_reg;
    assign sprite_done = od_reg;

endmodule

/* hw/rtl/alpha_weighted_box_downscale.sv */
// Top level of the alpha-weighted box downscaler.
// Shrinks a raster-order RGBA image to a SPRITE_SIDE square sprite by area averaging
// and posterizes each opaque box to 24 levels. Each pixel passes through the front
// end's accept and accumulate states, a read-modify-write of the column-sum memory;
// a finished box then passes through the back end (load, 5 restoring divide steps,
// post, hand over), overlapped with later pixels through a 2-entry job queue. Writing
// a size register restarts the image at once through per-column valid bits, with no
// clearing pass.
module alpha_weighted_box_downscale #(
    parameter int SPRITE_SIDE = 32,
    parameter int MAX_SOURCE_SIDE = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  src_red,
    input  logic [7:0]  src_green,
    input  logic [7:0]  src_blue,
    input  logic [7:0]  src_alpha,
    output logic        empty,
    input  logic        pop,
    output logic [12:0] atlas_x,
    output logic [12:0] atlas_y,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic        sprite_done,
    input  logic        cfg_write,
    input  logic [awbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [awbd_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "alpha_weighted_box_downscale_defines.svh"

    localparam int CW   = $clog2(SPRITE_SIDE);
    localparam int SW   = $clog2(MAX_SOURCE_SIDE + 1);
    localparam int BOX  = MAX_SOURCE_SIDE / SPRITE_SIDE + 1;
    localparam int CNTW = $clog2(BOX * BOX + 1);
    localparam int JW   = 3 * (CNTW + 16) + (CNTW + 8) + CNTW + 2 * CW + 1;

    logic [10:0]   width_reg, height_reg;
    logic [11:0]   dest_x_reg, dest_y_reg;
    logic [SW-1:0] width_eff, height_eff;
    logic          restart;
    logic          q_full, q_empty, q_push, q_pop;
    logic [JW-1:0] q_wdata, q_rdata;

    assign restart = cfg_write && ((cfg_index == awbd_pkg::REG_SOURCE_WIDTH)
                  || (cfg_index == awbd_pkg::REG_SOURCE_HEIGHT));

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd32;
            height_reg <= 11'd32;
            dest_x_reg <= 12'd0;
            dest_y_reg <= 12'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                awbd_pkg::REG_SOURCE_WIDTH:  width_reg  <= cfg_data[10:0];
                awbd_pkg::REG_SOURCE_HEIGHT: height_reg <= cfg_data[10:0];
                awbd_pkg::REG_DEST_X:        dest_x_reg <= cfg_data;
                awbd_pkg::REG_DEST_Y:        dest_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the image size to the supported range
    always_comb
    begin
        width_eff  = (32'(width_reg) < SPRITE_SIDE) ? SW'(SPRITE_SIDE)
                   : (32'(width_reg) > MAX_SOURCE_SIDE) ? SW'(MAX_SOURCE_SIDE) : SW'(width_reg);
        height_eff = (32'(height_reg) < SPRITE_SIDE) ? SW'(SPRITE_SIDE)
                   : (32'(height_reg) > MAX_SOURCE_SIDE) ? SW'(MAX_SOURCE_SIDE) : SW'(height_reg);
    end

    awbd_front #(
        .SPRITE_SIDE(SPRITE_SIDE), .MAX_SOURCE_SIDE(MAX_SOURCE_SIDE),
        .CW(CW), .SW(SW), .CNTW(CNTW), .JW(JW)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .src_red(src_red), .src_green(src_green), .src_blue(src_blue), .src_alpha(src_alpha),
        .width_eff(width_eff), .height_eff(height_eff), .restart(restart),
        .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
    );

    awbd_queue #(.JW(JW)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr(q_push), .wdata(q_wdata), .q_full(q_full),
        .rd(q_pop), .q_empty(q_empty), .rdata(q_rdata)
    );

    awbd_back #(.CW(CW), .CNTW(CNTW), .JW(JW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
        .dest_x(dest_x_reg), .dest_y(dest_y_reg), .empty(empty), .pop(pop),
        .atlas_x(atlas_x), .atlas_y(atlas_y), .out_red(out_red), .out_green(out_green),
        .out_blue(out_blue), .out_alpha(out_alpha), .sprite_done(sprite_done)
    );

    // A finished box never meets a full queue
    `AWBD_ASSERT_IMPL(a_no_overflow, q_push, !q_full)
    // A transparent result carries no colour
    `AWBD_ASSERT_IMPL(a_clear_black, !empty && out_alpha == 8'd0,
        out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    // Alpha is either fully on or fully off
    `AWBD_ASSERT_IMPL(a_alpha_binary, !empty, out_alpha == 8'd0 || out_alpha == 8'hFF)
    // A transfer out frees the result slot
    `AWBD_ASSERT_NEXT(a_pop_frees, pop && !empty, empty)

endmodule
